// ===== rtl/core/rwpdf_pkg.sv =====
// shared widths, codes and constants of the random walk first-passage block
// no dependencies; compiled first
package rwpdf_pkg;

  localparam int MAX_HALF_WIDTH_DEF = 511;
  localparam int MIN_HALF_WIDTH     = 2;

  localparam int CFG_W  = 9;
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;

  localparam int MASS_W = 64;
  localparam int PROB_W = 33;
  localparam int FP_W   = 63;
  localparam int TS_W   = 32;

  localparam logic [CFG_W-1:0]  HALF_RESET = 9'd511;
  localparam logic [PROB_W-1:0] PROB_ONE   = 33'h1_0000_0000;
  localparam logic [MASS_W-1:0] MASS_ONE   = 64'h8000_0000_0000_0000;

  // register index, taken from cfg_paddr[2]
  localparam logic REG_HALF_WIDTH = 1'b0;

  typedef enum logic {
    CMD_RESTART = 1'b0,
    CMD_SITE    = 1'b1
  } cmd_t;

endpackage

// ===== rtl/core/rwpdf_if.sv =====
// valid/ready stream interfaces for the site input and the result output
// depends on rwpdf_pkg
interface rwpdf_in_if;
  logic                           valid;
  logic                           ready;
  rwpdf_pkg::cmd_t                command;
  logic [rwpdf_pkg::PROB_W-1:0]   step_prob;

  modport source (output valid, command, step_prob, input ready);
  modport sink   (input valid, command, step_prob, output ready);
endinterface

interface rwpdf_out_if;
  logic                           valid;
  logic                           ready;
  logic [rwpdf_pkg::FP_W-1:0]     first_passage;
  logic [rwpdf_pkg::TS_W-1:0]     time_step;

  modport source (output valid, first_passage, time_step, input ready);
  modport sink   (input valid, first_passage, time_step, output ready);
endinterface

// ===== rtl/core/rwpdf_ram.sv =====
// generic single write port ram with one registered read port
// no dependencies beyond rwpdf_pkg defaults
module rwpdf_ram #(
  parameter int WIDTH = rwpdf_pkg::MASS_W,
  parameter int DEPTH = 2 * rwpdf_pkg::MAX_HALF_WIDTH_DEF + 1,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/random_walk_pdf_time_step.sv =====
// random walk first-passage engine: one site update per beat over a mass ram
// depends on rwpdf_pkg, rwpdf_if (rwpdf_in_if, rwpdf_out_if) and rwpdf_ram
//
// The block takes one site beat per clock while input is not held off:
// command 1 carries the left-move probability of the next site, command 0
// restarts with unit mass at the centre. Sites stream through a four-stage
// pipeline around the mass ram (read, split multiply, product sum, update
// and write back), so the result of the last site is registered on out_ch
// when that site leaves the update stage. Input is held off only while a
// result sits unclaimed in the output register and the next result has
// reached the last stage. The ram is never cleared: a fill mark makes
// unwritten sites read as the restart pattern, so restart and reset need no
// clearing pass. A site is written back in the update stage of a later beat,
// before it is read again, which the minimum sweep length of five sites guarantees.
module random_walk_pdf_time_step #(
  parameter int MAX_HALF_WIDTH = rwpdf_pkg::MAX_HALF_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  rwpdf_in_if.sink                     in_ch,
  rwpdf_out_if.source                  out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [rwpdf_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [rwpdf_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [rwpdf_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                         cfg_pready
);

  localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = rwpdf_pkg::MASS_W;
  localparam int PW    = rwpdf_pkg::PROB_W;
  localparam int TW    = rwpdf_pkg::TS_W;
  localparam int RESET_CENTRE_I = (MAX_HALF_WIDTH < int'(rwpdf_pkg::HALF_RESET)) ?
                                  MAX_HALF_WIDTH : int'(rwpdf_pkg::HALF_RESET);
  localparam logic [AW-1:0] RESET_CENTRE = AW'(RESET_CENTRE_I);

  typedef struct packed {
    logic [AW-1:0] k;
    logic          first;
    logic          second;
    logic          third;
    logic          last;
    logic [TW-1:0] ts;
  } ctrl_t;

  function automatic logic [MW-1:0] sat_add(input logic [MW-1:0] a, input logic [MW-1:0] b);
    logic [MW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[MW] ? '1 : s[MW-1:0];
  endfunction

  // configuration
  logic [rwpdf_pkg::CFG_W-1:0] half_cfg_r;
  logic                        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == rwpdf_pkg::REG_HALF_WIDTH) ?
                      {{(rwpdf_pkg::CFG_DW-rwpdf_pkg::CFG_W){1'b0}}, half_cfg_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_cfg_r <= rwpdf_pkg::HALF_RESET;
    end else if (cfg_wr && cfg_paddr[2] == rwpdf_pkg::REG_HALF_WIDTH) begin
      half_cfg_r <= cfg_pwdata[rwpdf_pkg::CFG_W-1:0];
    end
  end

  // sweep control
  logic [31:0]   cfg32, eff32;
  logic [AW-1:0] eff_h, sweep_len, k, k_inc, fill_hi;
  logic [AW-1:0] site_cnt_r, site_cnt_nxt, fill_r, fill_nxt, centre_r;
  logic [TW-1:0] step_cnt_r, step_inc;
  logic          adv, in_fire, site_fire, restart_fire, last;
  logic [PW-1:0] p_sat;

  assign cfg32 = {{(32-rwpdf_pkg::CFG_W){1'b0}}, half_cfg_r};
  assign eff32 = (cfg32 < 32'(rwpdf_pkg::MIN_HALF_WIDTH)) ? 32'(rwpdf_pkg::MIN_HALF_WIDTH) :
                 (cfg32 > 32'(MAX_HALF_WIDTH)) ? 32'(MAX_HALF_WIDTH) : cfg32;
  assign eff_h     = eff32[AW-1:0];
  assign sweep_len = AW'((eff32 << 1) + 32'd1);

  assign k        = (site_cnt_r >= sweep_len) ? '0 : site_cnt_r;
  assign k_inc    = k + AW'(1);
  assign last     = (k == sweep_len - AW'(1));
  assign step_inc = step_cnt_r + TW'(1);

  assign in_ch.ready  = adv;
  assign in_fire      = in_ch.valid && adv;
  assign site_fire    = in_fire && (in_ch.command == rwpdf_pkg::CMD_SITE);
  assign restart_fire = in_fire && (in_ch.command == rwpdf_pkg::CMD_RESTART);

  assign p_sat = (in_ch.step_prob > rwpdf_pkg::PROB_ONE) ? rwpdf_pkg::PROB_ONE :
                 in_ch.step_prob;

  // sites below the fill mark hold written data
  assign fill_hi      = last ? k_inc : k;
  assign fill_nxt     = (fill_hi > fill_r) ? fill_hi : fill_r;
  assign site_cnt_nxt = last ? '0 : k_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      site_cnt_r <= '0;
      fill_r     <= '0;
      centre_r   <= RESET_CENTRE;
      step_cnt_r <= '0;
    end else if (restart_fire) begin
      site_cnt_r <= '0;
      fill_r     <= '0;
      centre_r   <= eff_h;
      step_cnt_r <= '0;
    end else if (site_fire) begin
      site_cnt_r <= site_cnt_nxt;
      fill_r     <= fill_nxt;
      if (last) begin
        step_cnt_r <= step_inc;
      end
    end
  end

  // stage a: ram read in flight
  logic          a_valid_r, a_ent_ok_r, a_centre_r;
  ctrl_t         a_ctrl_r;
  logic [PW-1:0] a_p_r;

  // stage b: split products
  logic          b_valid_r;
  ctrl_t         b_ctrl_r;
  logic [MW-1:0] b_m_r, b_rhi_r, b_lhi_r;
  logic [PW-1:0] b_rlo_r, b_llo_r;

  // stage c: products summed
  logic          c_valid_r;
  ctrl_t         c_ctrl_r;
  logic [MW-1:0] c_m_r, c_r_r, c_lf_r;

  // ram
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [MW-1:0] ram_wdata, ram_rdata;

  rwpdf_ram #(
    .WIDTH(MW),
    .DEPTH(DEPTH)
  ) u_mass_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (adv),
    .raddr(k),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= site_fire;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ctrl_r.k      <= k;
      a_ctrl_r.first  <= (k == '0);
      a_ctrl_r.second <= (k == AW'(1));
      a_ctrl_r.third  <= (k == AW'(2));
      a_ctrl_r.last   <= last;
      a_ctrl_r.ts     <= step_inc;
      a_p_r           <= p_sat;
      a_ent_ok_r      <= (k < fill_r);
      a_centre_r      <= (k == centre_r);
    end
  end

  logic [MW-1:0]   m_b;
  logic [PW-1:0]   q_b;
  logic [MW:0]     rhi_b, rlo_b, lhi_b, llo_b;

  assign m_b   = a_ent_ok_r ? ram_rdata : (a_centre_r ? rwpdf_pkg::MASS_ONE : '0);
  assign q_b   = rwpdf_pkg::PROB_ONE - a_p_r;
  assign rhi_b = (MW+1)'(a_p_r) * (MW+1)'(m_b[MW-1:32]);
  assign rlo_b = (MW+1)'(a_p_r) * (MW+1)'(m_b[31:0]);
  assign lhi_b = (MW+1)'(q_b) * (MW+1)'(m_b[MW-1:32]);
  assign llo_b = (MW+1)'(q_b) * (MW+1)'(m_b[31:0]);

  always_ff @(posedge clk) begin
    if (adv) begin
      b_ctrl_r <= a_ctrl_r;
      b_m_r    <= m_b;
      b_rhi_r  <= rhi_b[MW-1:0];
      b_rlo_r  <= rlo_b[MW:32];
      b_lhi_r  <= lhi_b[MW-1:0];
      b_llo_r  <= llo_b[MW:32];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_ctrl_r <= b_ctrl_r;
      c_m_r    <= b_m_r;
      c_r_r    <= b_rhi_r + {{(MW-PW){1'b0}}, b_rlo_r};
      c_lf_r   <= b_lhi_r + {{(MW-PW){1'b0}}, b_llo_r};
    end
  end

  // stage d: window of the two previous sites, write back, result
  logic [MW-1:0] w_m1_r, w_lf1_r, w_lf2_r, acc_r;
  logic [MW-1:0] nv_d, end_d, acc_out;
  logic          d_fire, d_write;
  logic          pend_valid_r;
  logic [AW-1:0] pend_addr_r;
  logic [MW-1:0] pend_data_r;
  logic          out_valid_r;
  logic [rwpdf_pkg::FP_W-1:0] out_fp_r;
  logic [TW-1:0] out_ts_r;

  assign adv     = !(c_valid_r && c_ctrl_r.last && out_valid_r && !out_ch.ready);
  assign d_fire  = adv && c_valid_r;
  assign d_write = d_fire && !c_ctrl_r.first;

  always_comb begin
    if (c_ctrl_r.second) begin
      nv_d = sat_add(w_m1_r, c_r_r);
    end else if (c_ctrl_r.third) begin
      nv_d = c_r_r;
    end else if (c_ctrl_r.last) begin
      nv_d = w_lf2_r;
    end else begin
      nv_d = sat_add(w_lf2_r, c_r_r);
    end
  end

  assign end_d   = sat_add(c_m_r, w_lf1_r);
  assign acc_out = sat_add(acc_r, w_lf1_r);

  // the beat after a last site never writes, so its slot takes the end site
  assign ram_we    = pend_valid_r || d_write;
  assign ram_waddr = pend_valid_r ? pend_addr_r : c_ctrl_r.k - AW'(1);
  assign ram_wdata = pend_valid_r ? pend_data_r : nv_d;

  always_ff @(posedge clk) begin
    if (d_fire) begin
      w_m1_r  <= c_m_r;
      w_lf1_r <= c_lf_r;
      w_lf2_r <= w_lf1_r;
      if (c_ctrl_r.first) begin
        acc_r <= '0;
      end else if (c_ctrl_r.second) begin
        acc_r <= sat_add(acc_r, c_r_r);
      end
      if (c_ctrl_r.last) begin
        pend_addr_r <= c_ctrl_r.k;
        pend_data_r <= end_d;
        out_fp_r    <= acc_out[MW-1] ? '1 : acc_out[rwpdf_pkg::FP_W-1:0];
        out_ts_r    <= c_ctrl_r.ts;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= d_fire && c_ctrl_r.last;
      if (d_fire && c_ctrl_r.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.first_passage = out_fp_r;
  assign out_ch.time_step     = out_ts_r;

endmodule

// ===== rtl/core/rwpdf_checker.sv =====
// port-level checks of the random walk first-passage block, bound to its top level
// depends on rwpdf_pkg and random_walk_pdf_time_step
module rwpdf_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rwpdf_pkg::FP_W-1:0]   out_first_passage,
  input logic [rwpdf_pkg::TS_W-1:0]   out_time_step,
  input logic                         cfg_psel,
  input logic                         cfg_penable,
  input logic                         cfg_pwrite,
  input logic [rwpdf_pkg::CFG_AW-1:0] cfg_paddr,
  input logic [rwpdf_pkg::CFG_DW-1:0] cfg_pwdata,
  input logic [rwpdf_pkg::CFG_DW-1:0] cfg_prdata
);

  // a result beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_first_passage) &&
    $stable(out_time_step))
    else $error("result beat dropped or changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input is only held off behind a waiting result
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(cfg_psel && cfg_penable && cfg_pwrite &&
    cfg_paddr[2] == rwpdf_pkg::REG_HALF_WIDTH) && cfg_psel && !cfg_pwrite &&
    cfg_paddr[2] == rwpdf_pkg::REG_HALF_WIDTH
    |-> cfg_prdata == {{(rwpdf_pkg::CFG_DW-rwpdf_pkg::CFG_W){1'b0}},
                       $past(cfg_pwdata[rwpdf_pkg::CFG_W-1:0])})
    else $error("half width readback mismatch");

endmodule

bind random_walk_pdf_time_step rwpdf_checker u_rwpdf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_first_passage(out_ch.first_passage),
  .out_time_step    (out_ch.time_step),
  .cfg_psel         (cfg_psel),
  .cfg_penable      (cfg_penable),
  .cfg_pwrite       (cfg_pwrite),
  .cfg_paddr        (cfg_paddr),
  .cfg_pwdata       (cfg_pwdata),
  .cfg_prdata       (cfg_prdata)
);

// ===== tb/sv/random_walk_pdf_time_step_test.sv =====
// self-checking testbench for random_walk_pdf_time_step: site beats in, first-passage results out
// depends on rwpdf_pkg, rwpdf_in_if, rwpdf_out_if and the block itself
// a scoreboard class predicts each result from the accepted beats and checks the output stream
module random_walk_pdf_time_step_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rwpdf_pkg::*;

  localparam int HALF_MAX       = MAX_HALF_WIDTH_DEF;
  localparam int STORE_DEPTH    = 2 * HALF_MAX + 1;
  localparam int WIDE_HALF      = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int LONG_HOLD      = 300;
  localparam int STUCK_LIMIT    = 3000;
  localparam int PHASE_ITEMS    = 60;
  localparam int PHASE_PASSAGES = 6;

  typedef struct packed {
    logic [FP_W-1:0] first_passage;
    logic [TS_W-1:0] time_step;
  } passage_t;

  class walk_tracker;
    logic [CFG_W-1:0]  half_reg;
    logic [MASS_W-1:0] mass [STORE_DEPTH];
    int unsigned       next_site;
    logic [MASS_W-1:0] old_mass [3];
    logic [PROB_W-1:0] old_prob [3];
    logic [TS_W-1:0]   steps;
    logic [MASS_W-1:0] absorbed;
    passage_t          passage_due [$];
    int unsigned       errors;

    function new();
      half_reg = HALF_RESET;
      errors = 0;
      restart();
    endfunction

    function int unsigned eff_half();
      if (half_reg < MIN_HALF_WIDTH) return MIN_HALF_WIDTH;
      if (half_reg > HALF_MAX) return HALF_MAX;
      return half_reg;
    endfunction

    function void restart();
      foreach (mass[i]) mass[i] = '0;
      mass[eff_half()] = MASS_ONE;
      next_site = 0;
      foreach (old_mass[i]) old_mass[i] = '0;
      foreach (old_prob[i]) old_prob[i] = '0;
      steps = '0;
      absorbed = '0;
    endfunction

    function void set_half(logic [CFG_W-1:0] value);
      half_reg = value;
    endfunction

    // floor(p * m / 2^32), never above m
    function logic [MASS_W-1:0] scale(logic [PROB_W-1:0] p, logic [MASS_W-1:0] m);
      logic [PROB_W+MASS_W-1:0] prod;
      prod = {{MASS_W{1'b0}}, p} * {{PROB_W{1'b0}}, m};
      return prod[MASS_W+31:32];
    endfunction

    function logic [MASS_W-1:0] add_sat(logic [MASS_W-1:0] a, logic [MASS_W-1:0] b);
      logic [MASS_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[MASS_W] ? '1 : s[MASS_W-1:0];
    endfunction

    function void take_site(cmd_t cmd, logic [PROB_W-1:0] prob);
      int unsigned       len;
      int unsigned       k;
      int unsigned       j;
      logic [PROB_W-1:0] p;
      logic [MASS_W-1:0] from_r;
      logic [MASS_W-1:0] from_l;
      logic [MASS_W-1:0] into_end;
      logic [MASS_W-1:0] nv;
      passage_t          res;
      if (cmd == CMD_RESTART) begin
        restart();
        return;
      end
      len = 2 * eff_half() + 1;
      p = (prob > PROB_ONE) ? PROB_ONE : prob;
      if (next_site >= len) next_site = 0;
      k = next_site;
      if (k == 0) absorbed = '0;
      old_mass[0] = old_mass[1];
      old_mass[1] = old_mass[2];
      old_mass[2] = mass[k];
      old_prob[0] = old_prob[1];
      old_prob[1] = old_prob[2];
      old_prob[2] = p;
      if (k >= 1) begin
        j = k - 1;
        from_r = scale(old_prob[2], old_mass[2]);
        from_l = scale(PROB_ONE - old_prob[0], old_mass[0]);
        if (j == 0) begin
          nv = add_sat(old_mass[1], from_r);
          absorbed = add_sat(absorbed, from_r);
        end else if (j == 1) begin
          nv = from_r;
        end else if (j == len - 2) begin
          nv = from_l;
        end else begin
          nv = add_sat(from_l, from_r);
        end
        mass[j] = nv;
      end
      if (k == len - 1) begin
        into_end = scale(PROB_ONE - old_prob[1], old_mass[1]);
        mass[k] = add_sat(old_mass[2], into_end);
        absorbed = add_sat(absorbed, into_end);
        steps = steps + 1'b1;
        next_site = 0;
        res.first_passage = absorbed[MASS_W-1] ? {FP_W{1'b1}} : absorbed[FP_W-1:0];
        res.time_step = steps;
        passage_due.push_back(res);
      end else begin
        next_site = k + 1;
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_passage(logic [FP_W-1:0] fp, logic [TS_W-1:0] ts);
      passage_t due;
      if (passage_due.size() == 0) begin
        report($sformatf("result with nothing due: first_passage %h time_step %0d", fp, ts));
        return;
      end
      due = passage_due.pop_front();
      if (fp !== due.first_passage)
        report($sformatf("first_passage %h, want %h (step %0d)", fp, due.first_passage,
                         due.time_step));
      if (ts !== due.time_step)
        report($sformatf("time_step %0d, want %0d", ts, due.time_step));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  rwpdf_in_if  in_ch ();
  rwpdf_out_if out_ch ();

  walk_tracker walk = new();

  int unsigned items_sent = 0;
  int unsigned passages_seen = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned stuck_cycles = 0;
  int unsigned hold_cnt = 0;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;

  random_walk_pdf_time_step uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // receiver: random stalls, plus a long hold on request
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_cnt = LONG_HOLD;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      walk.check_passage(out_ch.first_passage, out_ch.time_step);
      passages_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("random_walk_pdf_time_step_test: FAIL");
      $finish;
    end
  end

  function automatic logic [PROB_W-1:0] pick_prob();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return PROB_ONE;
    if (r < 22) return {1'b1, 32'($urandom)};
    return {1'b0, 32'($urandom)};
  endfunction

  function automatic logic [CFG_W-1:0] pick_half();
    if ($urandom_range(99) < 80) return CFG_W'($urandom_range(0, 6));
    return CFG_W'($urandom_range(7, 20));
  endfunction

  task automatic send_beat(cmd_t cmd, logic [PROB_W-1:0] prob);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.command <= cmd_t'($urandom_range(1));
      in_ch.step_prob <= PROB_W'({$urandom, $urandom});
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.step_prob <= prob;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    walk.take_site(cmd, prob);
    items_sent++;
  endtask

  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (walk.passage_due.size() != 0);
  endtask

  task automatic settle();
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_half(logic [CFG_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {REG_HALF_WIDTH, 2'b00};
    cfg_pwdata <= {23'($urandom), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    walk.set_half(value);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct);
    int unsigned start_items;
    int unsigned start_passages;
    int unsigned len;
    int unsigned r;
    start_items = items_sent;
    start_passages = passages_seen;
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
    while (items_sent - start_items < PHASE_ITEMS ||
           passages_seen - start_passages < PHASE_PASSAGES) begin
      r = $urandom_range(99);
      len = 2 * walk.eff_half() + 1;
      if (r < 78) begin
        repeat ((walk.next_site >= len) ? len : len - walk.next_site)
          send_beat(CMD_SITE, pick_prob());
      end else if (r < 86) begin
        send_beat(CMD_RESTART, PROB_W'({$urandom, $urandom}));
      end else if (r < 93) begin
        repeat ($urandom_range(1, len - 1)) send_beat(CMD_SITE, pick_prob());
      end else if (r < 96) begin
        settle();
        write_half(pick_half());
      end else begin
        pause_until_drained();
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_RESTART;
    in_ch.step_prob = '0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // partial sweep at the reset width, then shrink so the sweep is abandoned
    send_beat(CMD_SITE, '0);
    send_beat(CMD_SITE, PROB_ONE);
    send_beat(CMD_SITE, {PROB_W{1'b1}});
    send_beat(CMD_SITE, 33'h0_FFFF_FFFF);
    send_beat(CMD_SITE, 33'h1_0000_0001);
    send_beat(CMD_SITE, pick_prob());
    settle();
    write_half(9'd0);
    repeat (5) send_beat(CMD_SITE, 33'h0_8000_0000);
    // all mass drifts right into the end site: the reported first passage saturates
    send_beat(CMD_RESTART, {PROB_W{1'b1}});
    repeat (10) send_beat(CMD_SITE, '0);

    // one sweep over a wide array
    settle();
    write_half(CFG_W'(WIDE_HALF));
    send_beat(CMD_RESTART, pick_prob());
    repeat (2 * WIDE_HALF + 1) send_beat(CMD_SITE, pick_prob());

    settle();
    write_half(9'd1);
    hold_toggle <= ~hold_toggle;
    run_phase(0, 0);
    pause_until_drained();

    settle();
    write_half(pick_half());
    run_phase(80, 0);
    settle();
    write_half(pick_half());
    run_phase(0, 80);
    settle();
    write_half(pick_half());
    run_phase(14, 14);

    settle();
    if (walk.errors == 0) begin
      $display("random_walk_pdf_time_step_test: PASS");
    end else begin
      $display("random_walk_pdf_time_step_test: FAIL");
    end
    $finish;
  end

endmodule
